// File: design/vbp_pkg.sv
// Shared types and constants of the volume block partitioner.
// No dependencies; the datapath, controller and top level import this package.
package vbp_pkg;

    // Field widths.
    localparam int DIM_W   = 13;  // dimensions and sizes
    localparam int START_W = 12;  // output start fields
    localparam int BPV_W   = 4;   // bytes per voxel
    localparam int DIV_CW  = 11;  // division count and split factors
    localparam int IDX_W   = 10;  // block index
    localparam int CNT_W   = 12;  // search counters, may step one past the count
    localparam int OFF_W   = 39;  // first row byte offset
    localparam int ROW_W   = 16;  // row length in bytes
    localparam int CFG_AW  = 3;   // configuration register index
    localparam int CFG_DW  = 13;  // configuration write data

    // Divider operand width, wide enough for every dividend and divisor.
    localparam int QW = DIM_W;

    // Defaults of the top level parameters.
    localparam int DEF_MAX_DIM       = 4096;
    localparam int DEF_MAX_DIVISIONS = 1024;
    localparam int VOXEL_BYTES_MAX   = 8;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_DIM_X     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DIM_Y     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_DIM_Z     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BPV       = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DIV_COUNT = 3'd4;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_INIT,
        OP_DIV_DX,
        OP_NEXT_X,
        OP_SET_REM,
        OP_DIV_RY,
        OP_NEXT_Y,
        OP_EVAL,
        OP_KNOWN,
        OP_DIV_IX,
        OP_SAVE_BX,
        OP_DIV_TY,
        OP_SAVE_BY,
        OP_DIV_AX,
        OP_SPAN_X,
        OP_DIV_AY,
        OP_SPAN_Y,
        OP_DIV_AZ,
        OP_SPAN_Z,
        OP_OFF1,
        OP_OFF2,
        OP_OFF3
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;   // divider finished this cycle
        logic rem_zero;   // divider remainder is zero
        logic x_over;     // x counter passed the division count
        logic y_over;     // y counter passed the quotient d / x
        logic eval_zero;  // candidate split is a perfect cube
        logic bad;        // latched index is out of range
        logic known;      // split is cached
    } t_stat;

endpackage

// File: design/vbp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the datapath.
module vbp_div #(
    parameter int W = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    w_shift;
    logic          w_ge;
    logic [W:0]    w_diff;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(W - 1);
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
            end else if (r_run) begin
                r_rem <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// File: design/vbp_dp.sv
// Datapath: configuration registers, split search registers, shared divider,
// block span and offset arithmetic. Depends on vbp_pkg and vbp_div.
module vbp_dp #(
    parameter int MAX_DIM       = vbp_pkg::DEF_MAX_DIM,
    parameter int MAX_DIVISIONS = vbp_pkg::DEF_MAX_DIVISIONS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vbp_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [vbp_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic [vbp_pkg::IDX_W-1:0]   i_block_index,
    input  vbp_pkg::t_cmd               i_cmd,
    output vbp_pkg::t_stat              o_stat,
    output logic [vbp_pkg::START_W-1:0] o_start_x,
    output logic [vbp_pkg::START_W-1:0] o_start_y,
    output logic [vbp_pkg::START_W-1:0] o_start_z,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_x,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_y,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_z,
    output logic [vbp_pkg::OFF_W-1:0]   o_first_row_offset,
    output logic [vbp_pkg::ROW_W-1:0]   o_row_bytes,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_x_out,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_y_out,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_z_out,
    output logic                        o_bad_index
);
    import vbp_pkg::*;

    localparam int AW = 2 * DIM_W + 1;  // sz * dy + sy
    localparam int BW = AW + DIM_W + 1; // a * dx + sx

    // Configuration and cached split.
    logic [DIM_W-1:0]  r_dim_x, r_dim_y, r_dim_z;
    logic [BPV_W-1:0]  r_bpv;
    logic [DIV_CW-1:0] r_div_cnt;
    logic              r_known;
    logic [DIV_CW-1:0] r_split_x, r_split_y, r_split_z;

    // Search and item registers.
    logic [CNT_W-1:0]  r_x, r_y;
    logic [QW-1:0]     r_rem_xy;
    logic [QW-1:0]     r_best;
    logic [IDX_W-1:0]  r_idx;
    logic [QW-1:0]     r_bx, r_by, r_bz, r_t;
    logic [DIM_W-1:0]  r_sx, r_sy, r_sz;
    logic [DIM_W-1:0]  r_wx, r_wy, r_wz;
    logic [AW-1:0]     r_a;
    logic [BW-1:0]     r_b;
    logic [OFF_W-1:0]  r_off;
    logic [ROW_W-1:0]  r_row;
    logic              r_bad;

    // Clamped configuration.
    logic [DIM_W-1:0]  w_dx, w_dy, w_dz;
    logic [BPV_W-1:0]  w_bpv;
    logic [DIV_CW-1:0] w_d;

    assign w_dx  = (32'(r_dim_x) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_dim_x;
    assign w_dy  = (32'(r_dim_y) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_dim_y;
    assign w_dz  = (32'(r_dim_z) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_dim_z;
    assign w_bpv = (32'(r_bpv) > 32'(VOXEL_BYTES_MAX)) ? BPV_W'(VOXEL_BYTES_MAX) : r_bpv;
    assign w_d   = (32'(r_div_cnt) > 32'(MAX_DIVISIONS)) ?
                   DIV_CW'(MAX_DIVISIONS) : r_div_cnt;

    // Shared divider with operand selection.
    logic          w_div_start;
    logic [QW-1:0] w_num, w_den, w_quo, w_rem;
    logic          w_div_done;

    always_comb begin
        w_div_start = 1'b1;
        w_num       = '0;
        w_den       = QW'(1);
        case (i_cmd.op)
            OP_DIV_DX: begin w_num = QW'(w_d);     w_den = QW'(r_x);       end
            OP_DIV_RY: begin w_num = r_rem_xy;     w_den = QW'(r_y);       end
            OP_DIV_IX: begin w_num = QW'(r_idx);   w_den = QW'(r_split_x); end
            OP_DIV_TY: begin w_num = r_t;          w_den = QW'(r_split_y); end
            OP_DIV_AX: begin w_num = w_dx;         w_den = QW'(r_split_x); end
            OP_DIV_AY: begin w_num = w_dy;         w_den = QW'(r_split_y); end
            OP_DIV_AZ: begin w_num = w_dz;         w_den = QW'(r_split_z); end
            default:   begin w_div_start = 1'b0;                           end
        endcase
    end

    vbp_div #(.W(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Candidate evaluation: x, y and z = quotient.
    logic [QW-1:0] w_cx, w_cy, w_mx, w_mn, w_diff;

    assign w_cx = QW'(r_x);
    assign w_cy = QW'(r_y);

    always_comb begin
        w_mx = w_cx;
        if (w_cy > w_mx) w_mx = w_cy;
        if (w_quo > w_mx) w_mx = w_quo;
        w_mn = w_cx;
        if (w_cy < w_mn) w_mn = w_cy;
        if (w_quo < w_mn) w_mn = w_quo;
        w_diff = w_mx - w_mn;
    end

    // Span of one axis from the divider result and the block coordinate.
    logic [QW-1:0]      w_coord;
    logic               w_lt;
    logic [DIM_W-1:0]   w_size;
    logic [2*QW-1:0]    w_prod;
    logic [DIM_W-1:0]   w_start;

    always_comb begin
        case (i_cmd.op)
            OP_SPAN_Y: w_coord = r_by;
            OP_SPAN_Z: w_coord = r_bz;
            default:   w_coord = r_bx;
        endcase
        w_lt    = w_coord < w_rem;
        w_size  = w_quo + DIM_W'(w_lt);
        w_prod  = w_coord * w_quo;
        w_start = DIM_W'(w_prod) + (w_lt ? w_coord : w_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x   <= DIM_W'(1);
            r_dim_y   <= DIM_W'(1);
            r_dim_z   <= DIM_W'(1);
            r_bpv     <= BPV_W'(1);
            r_div_cnt <= DIV_CW'(1);
            r_known   <= 1'b0;
            r_split_x <= DIV_CW'(1);
            r_split_y <= DIV_CW'(1);
            r_split_z <= DIV_CW'(1);
        end else if (i_cfg_we) begin
            r_known <= 1'b0;
            case (i_cfg_idx)
                REG_DIM_X:     r_dim_x   <= i_cfg_data;
                REG_DIM_Y:     r_dim_y   <= i_cfg_data;
                REG_DIM_Z:     r_dim_z   <= i_cfg_data;
                REG_BPV:       r_bpv     <= i_cfg_data[BPV_W-1:0];
                REG_DIV_COUNT: r_div_cnt <= i_cfg_data[DIV_CW-1:0];
                default:       ;
            endcase
        end else begin
            case (i_cmd.op)
                OP_INIT: begin
                    r_split_x <= DIV_CW'(1);
                    r_split_y <= DIV_CW'(1);
                    r_split_z <= DIV_CW'(1);
                end
                OP_EVAL: begin
                    if (w_diff < r_best) begin
                        r_split_x <= DIV_CW'(r_x);
                        r_split_y <= DIV_CW'(r_y);
                        r_split_z <= DIV_CW'(w_quo);
                    end
                end
                OP_KNOWN: r_known <= 1'b1;
                default:  ;
            endcase
        end
    end

    // Search and item datapath registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_idx <= i_block_index;
                r_bad <= 32'(i_block_index) >= 32'(w_d);
                r_sx  <= '0;
                r_sy  <= '0;
                r_sz  <= '0;
                r_wx  <= '0;
                r_wy  <= '0;
                r_wz  <= '0;
                r_off <= '0;
                r_row <= '0;
            end
            OP_INIT: begin
                r_x    <= CNT_W'(1);
                r_best <= '1;
            end
            OP_NEXT_X:  r_x <= r_x + 1'b1;
            OP_SET_REM: begin
                r_rem_xy <= w_quo;
                r_y      <= CNT_W'(1);
            end
            OP_NEXT_Y:  r_y <= r_y + 1'b1;
            OP_EVAL: begin
                if (w_diff < r_best) r_best <= w_diff;
                r_y <= r_y + 1'b1;
            end
            OP_SAVE_BX: begin
                r_bx <= w_rem;
                r_t  <= w_quo;
            end
            OP_SAVE_BY: begin
                r_by <= w_rem;
                r_bz <= w_quo;
            end
            OP_SPAN_X: begin r_sx <= w_start; r_wx <= w_size; end
            OP_SPAN_Y: begin r_sy <= w_start; r_wy <= w_size; end
            OP_SPAN_Z: begin r_sz <= w_start; r_wz <= w_size; end
            OP_OFF1:   r_a <= AW'(r_sz) * AW'(w_dy) + AW'(r_sy);
            OP_OFF2:   r_b <= BW'(r_a) * BW'(w_dx) + BW'(r_sx);
            OP_OFF3: begin
                r_off <= OFF_W'(r_b * w_bpv);
                r_row <= ROW_W'(r_wx) * ROW_W'(w_bpv);
            end
            default: ;
        endcase
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.rem_zero  = w_rem == '0;
    assign o_stat.x_over    = 32'(r_x) > 32'(w_d);
    assign o_stat.y_over    = QW'(r_y) > r_rem_xy || r_y[CNT_W-1];
    assign o_stat.eval_zero = w_diff == '0;
    assign o_stat.bad       = r_bad;
    assign o_stat.known     = r_known;

    assign o_start_x          = r_sx[START_W-1:0];
    assign o_start_y          = r_sy[START_W-1:0];
    assign o_start_z          = r_sz[START_W-1:0];
    assign o_size_x           = r_wx;
    assign o_size_y           = r_wy;
    assign o_size_z           = r_wz;
    assign o_first_row_offset = r_off;
    assign o_row_bytes        = r_row;
    assign o_parts_x_out      = r_split_x;
    assign o_parts_y_out      = r_split_y;
    assign o_parts_z_out      = r_split_z;
    assign o_bad_index        = r_bad;
endmodule

// File: design/vbp_ctrl.sv
// Controller state machine: sequences the split search and the per-beat
// divisions and multiplies. Depends on vbp_pkg.
module vbp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  vbp_pkg::t_stat i_stat,
    output vbp_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import vbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_XCHK, S_XDIV, S_YCHK, S_YDIV, S_KNOWN,
        S_BCHK, S_BXW, S_BY, S_BYW, S_AX, S_AXW, S_AY, S_AYW,
        S_AZ, S_AZW, S_OFF1, S_OFF2, S_OFF3, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_valid;
    t_op    w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_op    = OP_LATCH;
                    n_state = i_stat.known ? S_BCHK : S_INIT;
                end
            end
            S_INIT: begin
                w_op    = OP_INIT;
                n_state = S_XCHK;
            end
            S_XCHK: begin
                if (i_stat.x_over) begin
                    n_state = S_KNOWN;
                end else begin
                    w_op    = OP_DIV_DX;
                    n_state = S_XDIV;
                end
            end
            S_XDIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        w_op    = OP_SET_REM;
                        n_state = S_YCHK;
                    end else begin
                        w_op    = OP_NEXT_X;
                        n_state = S_XCHK;
                    end
                end
            end
            S_YCHK: begin
                if (i_stat.y_over) begin
                    w_op    = OP_NEXT_X;
                    n_state = S_XCHK;
                end else begin
                    w_op    = OP_DIV_RY;
                    n_state = S_YDIV;
                end
            end
            S_YDIV: begin
                if (i_stat.div_done) begin
                    if (!i_stat.rem_zero) begin
                        w_op    = OP_NEXT_Y;
                        n_state = S_YCHK;
                    end else begin
                        w_op    = OP_EVAL;
                        n_state = i_stat.eval_zero ? S_KNOWN : S_YCHK;
                    end
                end
            end
            S_KNOWN: begin
                w_op    = OP_KNOWN;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                if (i_stat.bad) begin
                    n_state = S_OUT;
                end else begin
                    w_op    = OP_DIV_IX;
                    n_state = S_BXW;
                end
            end
            S_BXW: begin
                if (i_stat.div_done) begin
                    w_op    = OP_SAVE_BX;
                    n_state = S_BY;
                end
            end
            S_BY: begin
                w_op    = OP_DIV_TY;
                n_state = S_BYW;
            end
            S_BYW: begin
                if (i_stat.div_done) begin
                    w_op    = OP_SAVE_BY;
                    n_state = S_AX;
                end
            end
            S_AX: begin
                w_op    = OP_DIV_AX;
                n_state = S_AXW;
            end
            S_AXW: begin
                if (i_stat.div_done) begin
                    w_op    = OP_SPAN_X;
                    n_state = S_AY;
                end
            end
            S_AY: begin
                w_op    = OP_DIV_AY;
                n_state = S_AYW;
            end
            S_AYW: begin
                if (i_stat.div_done) begin
                    w_op    = OP_SPAN_Y;
                    n_state = S_AZ;
                end
            end
            S_AZ: begin
                w_op    = OP_DIV_AZ;
                n_state = S_AZW;
            end
            S_AZW: begin
                if (i_stat.div_done) begin
                    w_op    = OP_SPAN_Z;
                    n_state = S_OFF1;
                end
            end
            S_OFF1: begin
                w_op    = OP_OFF1;
                n_state = S_OFF2;
            end
            S_OFF2: begin
                w_op    = OP_OFF2;
                n_state = S_OFF3;
            end
            S_OFF3: begin
                w_op    = OP_OFF3;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
            r_valid <= n_state == S_OUT;
        end
    end

    assign o_cmd.op = w_op;
    assign o_busy   = r_busy;
    assign o_valid  = r_valid;
endmodule

// File: design/volume_block_partitioner.sv
// Top level of the volume block partitioner: controller plus datapath.
// Depends on vbp_pkg, vbp_ctrl, vbp_dp (and vbp_div through the datapath).
//
//  Channel   | Direction | Handshake             | Payload
//  ----------+-----------+-----------------------+----------------------------------
//  command   | in        | start high, busy low  | i_block_index
//  result    | out       | o_valid, one cycle    | start, size, offset, row, parts, bad
//  config    | in        | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// A beat with a cached split runs five divisions on the one shared divider
// (issue, one step per quotient bit, done), three multiply steps for the
// offset, the result strobe and the return to idle before the next beat
// can be accepted. An out-of-range index skips the arithmetic and goes
// straight to the strobe. The first beat after reset or after any
// configuration write also runs the divisor search over the candidate
// factors on the shared divider.
// Reset is synchronous and active low; configuration and split registers return to
// one; the cached split drops. The result strobe cannot be stalled by the receiver.
module volume_block_partitioner #(
    parameter int MAX_DIM       = vbp_pkg::DEF_MAX_DIM,
    parameter int MAX_DIVISIONS = vbp_pkg::DEF_MAX_DIVISIONS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [vbp_pkg::IDX_W-1:0]   i_block_index,
    input  logic                        i_cfg_we,
    input  logic [vbp_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [vbp_pkg::CFG_DW-1:0]  i_cfg_data,
    output logic                        o_valid,
    output logic [vbp_pkg::START_W-1:0] o_start_x,
    output logic [vbp_pkg::START_W-1:0] o_start_y,
    output logic [vbp_pkg::START_W-1:0] o_start_z,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_x,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_y,
    output logic [vbp_pkg::DIM_W-1:0]   o_size_z,
    output logic [vbp_pkg::OFF_W-1:0]   o_first_row_offset,
    output logic [vbp_pkg::ROW_W-1:0]   o_row_bytes,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_x_out,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_y_out,
    output logic [vbp_pkg::DIV_CW-1:0]  o_parts_z_out,
    output logic                        o_bad_index
);
    import vbp_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller only accepts a beat in its idle state, so the start
    // strobe is passed straight through and qualified there.
    vbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // The datapath keeps the result fields in registers, so they stay stable
    // through the strobe cycle.
    vbp_dp #(
        .MAX_DIM       (MAX_DIM),
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_block_index      (i_block_index),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_start_x          (o_start_x),
        .o_start_y          (o_start_y),
        .o_start_z          (o_start_z),
        .o_size_x           (o_size_x),
        .o_size_y           (o_size_y),
        .o_size_z           (o_size_z),
        .o_first_row_offset (o_first_row_offset),
        .o_row_bytes        (o_row_bytes),
        .o_parts_x_out      (o_parts_x_out),
        .o_parts_y_out      (o_parts_y_out),
        .o_parts_z_out      (o_parts_z_out),
        .o_bad_index        (o_bad_index)
    );
endmodule
